@@ src/lfu_pkg.sv @@
package lfu_pkg;

  localparam int CAPACITY  = 16;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 16;
  localparam int STAMP_W   = 64;
  localparam int CAP_W     = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;

  typedef struct packed {
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic               match_found;
    logic [IDX_W-1:0]   match_idx;
    logic [DATA_W-1:0]  match_value;
    logic [COUNT_W-1:0] match_count;
    logic               vic_found;
    logic [IDX_W-1:0]   vic_idx;
    logic [DATA_W-1:0]  vic_key;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [CNT_W-1:0]   fill;
  } scan_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WB
  } state_t;

endpackage

@@ src/lfu_scan.sv @@
module lfu_scan
  import lfu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              en,
  input  logic              ent_valid,
  input  logic [IDX_W-1:0]  idx,
  input  entry_t            ent,
  input  logic [DATA_W-1:0] key,
  output scan_res_t         res
);

  logic [COUNT_W-1:0] vic_count;
  logic [STAMP_W-1:0] vic_stamp;
  logic               better;

  // lower count wins, equal counts go to the older stamp
  assign better = !res.vic_found || (ent.count < vic_count) ||
                  ((ent.count == vic_count) && (ent.stamp < vic_stamp));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      res.match_found <= 1'b0;
      res.vic_found   <= 1'b0;
      res.free_found  <= 1'b0;
      res.fill        <= '0;
    end else if (en) begin
      if (ent_valid) begin
        res.fill <= res.fill + CNT_W'(1);
        if (ent.key == key) begin
          res.match_found <= 1'b1;
          res.match_idx   <= idx;
          res.match_value <= ent.value;
          res.match_count <= ent.count;
        end
        if (better) begin
          res.vic_found <= 1'b1;
          res.vic_idx   <= idx;
          res.vic_key   <= ent.key;
          vic_count     <= ent.count;
          vic_stamp     <= ent.stamp;
        end
      end else if (!res.free_found) begin
        res.free_found <= 1'b1;
        res.free_idx   <= idx;
      end
    end
  end

endmodule

@@ src/lfu_cache_table.sv @@
// LFU key/value table, least recently used entry breaks count ties.
// Request channel: in_valid / in_stall with req_type (0 get, 1 put), key,
// value. A beat is taken when in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with hit, read_value, evicted,
// evicted_key, one result beat per request beat.
// Config channel: cfg_valid / cfg_ready with capacity; cfg_ready is always
// high. The user must write capacity only while no request is in flight;
// the block itself does not enforce this. Each request reads the entry
// memory one entry per cycle, then writes back at most one entry; a new
// request is taken only after the previous one has passed write-back,
// the sweep over the single read port of the entry memory setting the pace.
// The result sits in an output register, so the next request is taken while
// a result waits; a stalled receiver only holds back the write-back of the
// following request until its result register frees up.
// Reset empties the table (valid bits cleared), zeroes the access clock and
// sets capacity to 16; no clearing pass is needed.
module lfu_cache_table
  import lfu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     req_type,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic signed [DATA_W-1:0] read_value,
  output logic                     evicted,
  output logic signed [DATA_W-1:0] evicted_key,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         capacity
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  state_t state, state_next;

  logic [CAP_W-1:0]   capacity_q;
  logic               req_put;
  logic [DATA_W-1:0]  req_key;
  logic [DATA_W-1:0]  req_value;
  logic [IDX_W-1:0]   idx;
  logic               proc_en;
  logic [IDX_W-1:0]   proc_idx;
  logic [CAPACITY-1:0] entry_valid;
  logic [CAPACITY-1:0] entry_valid_next;
  logic [STAMP_W-1:0] access_clock;

  entry_t mem [CAPACITY];
  entry_t rd_data;
  entry_t wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  scan_res_t res;

  logic accept;
  logic issue;
  logic wb_go;

  logic               cap_zero;
  logic               fill_ge;
  logic               touch;
  logic               do_evict;
  logic               do_ins;
  logic [IDX_W-1:0]   ins_slot;
  logic [STAMP_W-1:0] clock_next;
  logic [COUNT_W-1:0] count_inc;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    issue      = 1'b0;
    wb_go      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        if (idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_WB;
      end
      ST_WB: begin
        if (!out_valid || !out_stall) begin
          wb_go      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity_q <= capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_put   <= req_type;
      req_key   <= key;
      req_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      proc_en <= 1'b0;
    end else begin
      proc_en <= issue;
      if (accept) begin
        idx <= '0;
      end else if (issue) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= idx;
  end

  // entry memory
  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  lfu_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .clr       (accept),
    .en        (proc_en),
    .ent_valid (entry_valid[proc_idx]),
    .idx       (proc_idx),
    .ent       (rd_data),
    .key       (req_key),
    .res       (res)
  );

  // write-back decision
  always_comb begin
    cap_zero   = (capacity_q == '0);
    fill_ge    = (32'(res.fill) >= ((32'(capacity_q) >= CAPACITY) ?
                                    32'(CAPACITY) : 32'(capacity_q)));
    touch      = res.match_found && (!req_put || !cap_zero);
    do_evict   = req_put && !cap_zero && !res.match_found && fill_ge &&
                 res.vic_found;
    do_ins     = req_put && !cap_zero && !res.match_found &&
                 (do_evict || res.free_found);
    ins_slot   = (do_evict && (!res.free_found || (res.vic_idx < res.free_idx))) ?
                 res.vic_idx : res.free_idx;
    clock_next = access_clock + STAMP_W'(1);
    count_inc  = (res.match_count == COUNT_MAX) ? res.match_count :
                 res.match_count + COUNT_W'(1);
    wr_en      = wb_go && (touch || do_ins);
    wr_addr    = touch ? res.match_idx : ins_slot;
    wr_data.key   = req_key;
    wr_data.stamp = clock_next;
    if (touch) begin
      wr_data.value = req_put ? req_value : res.match_value;
      wr_data.count = count_inc;
    end else begin
      wr_data.value = req_value;
      wr_data.count = COUNT_W'(1);
    end
    entry_valid_next = entry_valid;
    if (wb_go && do_evict) begin
      entry_valid_next[res.vic_idx] = 1'b0;
    end
    if (wb_go && do_ins) begin
      entry_valid_next[ins_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      access_clock <= '0;
    end else begin
      if (wr_en) begin
        access_clock <= clock_next;
      end
      entry_valid <= entry_valid_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      hit         <= touch;
      read_value  <= (!req_put && res.match_found) ? res.match_value : '0;
      evicted     <= do_evict;
      evicted_key <= do_evict ? res.vic_key : '0;
    end
  end

endmodule
